[hdl/assert_macros.svh]
// Assertion macros for the RTL of the pulse scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define DPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define DPS_ASSERT_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define DPS_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dps_pkg.sv]
// Package with payload types and constants of the delayed pulse scheduler.
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int DELAY_W        = 32;
    localparam int PENDING_W      = 5;

    typedef struct packed {
        logic               advance;
        logic               add_request;
        logic [DELAY_W-1:0] delay_ticks;
        logic               poll_request;
    } dps_req_t;

    typedef struct packed {
        logic                 pulse;
        logic                 dropped;
        logic [PENDING_W-1:0] pending;
    } dps_res_t;

endpackage

`default_nettype wire

[hdl/dps_slot_ram.sv]
// Slot memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dps_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/delayed_pulse_scheduler_core.sv]
// Top level of the delayed pulse scheduler: request sequencing and slot sweep.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries one time step:
//   advance, add_request with delay_ticks, and poll_request. The result channel
//   (res_valid, res_stall, res_data) returns one item per request: pulse,
//   dropped and the number of pending entries afterwards.
//   Each request sweeps the slot memory once, one slot per cycle through a
//   registered read, a decrement/compare and a write back. After acceptance
//   the sweep runs in ST_RUN; ST_DONE then loads the result into the output
//   register and returns to ST_IDLE, where the next request can be accepted.
//   The sweep length, set by the single read port of the slot memory, sets
//   the throughput. One request is in work at a time.
//   A finished result sits in an output register; a new request is accepted
//   while that result still waits. If the receiver stalls and a second
//   result is ready, the sweep holds its result until the register frees.
//   Reset clears all slot valid bits and the pending count at once; the
//   counter memory needs no clearing pass: no invalid slot's value is used.
`timescale 1ns / 1ps
`default_nettype none

module delayed_pulse_scheduler_core #(
    parameter int SLOTS      = dps_pkg::SLOTS_DEF,
    parameter int TIME_WIDTH = dps_pkg::TIME_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire dps_pkg::dps_req_t req_data,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output dps_pkg::dps_res_t      res_data
);

    import dps_pkg::*;

    `include "assert_macros.svh"

    localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CntW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CntW-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IdxW-1:0]       rd_idx_reg, rd_idx_next;
    logic [SLOTS-1:0]      slot_valid_reg, slot_valid_next;
    logic [CntW-1:0]       count_reg, count_next;
    logic                  adv_reg, adv_next;
    logic                  add_reg, add_next;
    logic                  poll_reg, poll_next;
    logic [TIME_WIDTH-1:0] delay_reg, delay_next;
    logic                  added_reg, added_next;
    logic                  polled_reg, polled_next;
    logic                  res_valid_reg, res_valid_next;
    dps_res_t              res_data_reg, res_data_next;

    logic                  rd_en;
    logic [TIME_WIDTH-1:0] rd_data;
    logic                  wr_en;
    logic [TIME_WIDTH-1:0] wr_val;
    logic                  cur_v;
    logic                  new_v;
    logic [TIME_WIDTH-1:0] dec_val;
    logic                  take_add;
    logic                  take_poll;
    logic                  last_slot;
    logic                  res_free;
    logic [TIME_WIDTH+DELAY_W-1:0] delay_ext;
    logic [CntW+PENDING_W-1:0]     count_ext;

    assign delay_ext = {{TIME_WIDTH{1'b0}}, req_data.delay_ticks};
    assign count_ext = {{PENDING_W{1'b0}}, count_reg};

    assign req_stall = (state_reg != ST_IDLE);
    assign rd_en     = (state_reg == ST_RUN) && (issue_cnt_reg < CntW'(SLOTS));
    assign last_slot = (rd_idx_reg == IdxW'(SLOTS - 1));
    assign res_free  = !res_valid_reg || !res_stall;

    dps_slot_ram #(
        .DEPTH  (SLOTS),
        .WIDTH  (TIME_WIDTH),
        .ADDR_W (IdxW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (rd_idx_reg),
        .wr_data (wr_val),
        .rd_en   (rd_en),
        .rd_addr (issue_cnt_reg[IdxW-1:0]),
        .rd_data (rd_data)
    );

    // Per-slot step: count down on advance, fill the first free slot, take the first due one.
    always_comb
    begin
        cur_v     = slot_valid_reg[rd_idx_reg];
        dec_val   = (cur_v && adv_reg && (rd_data != '0)) ? rd_data - TIME_WIDTH'(1) : rd_data;
        take_add  = rd_vld_reg && !cur_v && add_reg && !added_reg;
        new_v     = cur_v || take_add;
        wr_val    = take_add ? delay_reg : dec_val;
        take_poll = rd_vld_reg && poll_reg && !polled_reg && new_v && (wr_val == '0);
        wr_en     = rd_vld_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_vld_next     = rd_en;
        rd_idx_next     = rd_en ? issue_cnt_reg[IdxW-1:0] : rd_idx_reg;
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg + CntW'(take_add) - CntW'(take_poll);
        adv_next        = adv_reg;
        add_next        = add_reg;
        poll_next       = poll_reg;
        delay_next      = delay_reg;
        added_next      = added_reg || take_add;
        polled_next     = polled_reg || take_poll;
        res_valid_next  = res_valid_reg && res_stall;
        res_data_next   = res_data_reg;

        if (rd_vld_reg)
        begin
            slot_valid_next[rd_idx_reg] = new_v && !take_poll;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    adv_next       = req_data.advance;
                    add_next       = req_data.add_request;
                    poll_next      = req_data.poll_request;
                    delay_next     = delay_ext[TIME_WIDTH-1:0];
                    added_next     = 1'b0;
                    polled_next    = 1'b0;
                    issue_cnt_next = '0;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + CntW'(1);
                end
                if (rd_vld_reg && last_slot)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register frees
                if (res_free)
                begin
                    res_valid_next        = 1'b1;
                    res_data_next.pulse   = polled_reg;
                    res_data_next.dropped = add_reg && !added_reg;
                    res_data_next.pending = count_ext[PENDING_W-1:0];
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_cnt_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            slot_valid_reg <= '0;
            count_reg      <= '0;
            added_reg      <= 1'b0;
            polled_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_cnt_reg  <= issue_cnt_next;
            rd_vld_reg     <= rd_vld_next;
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            added_reg      <= added_next;
            polled_reg     <= polled_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        adv_reg      <= adv_next;
        add_reg      <= add_next;
        poll_reg     <= poll_next;
        delay_reg    <= delay_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `DPS_ASSERT_ALWAYS(a_count_matches, $countones(slot_valid_reg) == int'(count_reg), "pending count out of step with valid bits")
    `DPS_ASSERT_IMPLY(a_read_in_run, rd_vld_reg, state_reg == ST_RUN, "slot read data outside a sweep")
    // a dropped add saw every slot in use; a poll in the same sweep may have freed one
    `DPS_ASSERT_IMPLY(a_drop_when_full, (state_reg == ST_DONE) && res_free && add_reg && !added_reg, count_reg == CntW'(SLOTS) - CntW'(polled_reg), "add dropped with a free slot")
    `DPS_ASSERT_NEXT(a_one_take, rd_vld_reg && take_poll, polled_reg, "poll take not recorded")

endmodule

`default_nettype wire
